// File: rtl/leb_pkg.sv
// Shared constants, codes and control/status types of the line edit buffer.
package leb_pkg;

	// Port field widths
	localparam int KEY_W  = 8;
	localparam int KIND_W = 2;
	localparam int CHAR_W = 8;
	localparam int EV_W   = 3;
	localparam int POS_W  = 6;

	// Default store depth and reset value of the max length register
	localparam int                CAPACITY_DEF   = 32;
	localparam logic [POS_W-1:0]  MAX_LENGTH_RST = 6'd32;

	// Key codes
	localparam logic [KEY_W-1:0] KEY_PRINT_LO = 8'd33;
	localparam logic [KEY_W-1:0] KEY_PRINT_HI = 8'd127;
	localparam logic [KEY_W-1:0] KEY_PREFIX   = 8'd224;
	localparam logic [KEY_W-1:0] KEY_LEFT     = 8'd75;
	localparam logic [KEY_W-1:0] KEY_RIGHT    = 8'd77;
	localparam logic [KEY_W-1:0] KEY_HOME     = 8'd71;
	localparam logic [KEY_W-1:0] KEY_END      = 8'd79;
	localparam logic [KEY_W-1:0] KEY_BKSP     = 8'd8;
	localparam logic [KEY_W-1:0] KEY_ENTER    = 8'd13;
	localparam logic [KEY_W-1:0] KEY_ESC      = 8'd27;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

	// Event codes
	localparam logic [EV_W-1:0] EV_INSERTED  = 3'd0;
	localparam logic [EV_W-1:0] EV_IGNORED   = 3'd1;
	localparam logic [EV_W-1:0] EV_MOVED     = 3'd2;
	localparam logic [EV_W-1:0] EV_DELETED   = 3'd3;
	localparam logic [EV_W-1:0] EV_SUBMITTED = 3'd4;
	localparam logic [EV_W-1:0] EV_CANCELLED = 3'd5;
	localparam logic [EV_W-1:0] EV_PREFIX    = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic load_key;    // capture the accepted key
		logic start_ins;   // set up right shift for an insert
		logic start_del;   // set up left shift for a backspace
		logic shift_step;  // move one character
		logic start_emit;  // clear line, prime read of entry 0
		logic emit_char;   // load one line character result
		logic emit_end;    // load end-of-line result
		logic commit;      // update cursor/length/prefix and load status result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ins_ok;    // printable key that fits
		logic del_ok;    // backspace that deletes
		logic enter;     // enter with no prefix pending
		logic cnt_nz;    // shift/emit characters remain
		logic out_free;  // result register can load this cycle
	} sts_t;

endpackage

// File: rtl/leb_ctrl.sv
// Controller state machine of the line edit buffer.
module leb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  leb_pkg::sts_t sts,
	output leb_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SHIFT  = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_key = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.ins_ok) begin
					cmd.start_ins = 1'b1;
					state_d       = ST_SHIFT;
				end else if (sts.del_ok) begin
					cmd.start_del = 1'b1;
					state_d       = ST_SHIFT;
				end else if (sts.enter) begin
					cmd.start_emit = 1'b1;
					state_d        = ST_EMIT;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				// last step's write lands in the cycle that sees the count at zero
				if (sts.cnt_nz) begin
					cmd.shift_step = 1'b1;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.cnt_nz) begin
						cmd.emit_char = 1'b1;
					end else begin
						cmd.emit_end = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/leb_dpath.sv
// Datapath of the line edit buffer: line store, cursor, length, result register.
module leb_dpath #(
	parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  leb_pkg::cmd_t                 cmd,
	output leb_pkg::sts_t                 sts,
	input  logic [leb_pkg::KEY_W-1:0]     key_code,
	input  logic                          cfg_wr_en,
	input  logic [leb_pkg::POS_W-1:0]     cfg_wr_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [leb_pkg::KIND_W-1:0]    kind,
	output logic [leb_pkg::CHAR_W-1:0]    char_value,
	output logic [leb_pkg::EV_W-1:0]      event_res,
	output logic [leb_pkg::POS_W-1:0]     cursor,
	output logic [leb_pkg::POS_W-1:0]     length,
	output logic                          last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);

	// Line store
	logic [leb_pkg::CHAR_W-1:0] mem [CAPACITY];

	logic [leb_pkg::KEY_W-1:0]  key_q;
	logic                       pend_q;
	logic [PW-1:0]              cur_q, len_q;
	logic [leb_pkg::POS_W-1:0]  maxlen_q;
	logic [PW-1:0]              src_q, cnt_q;
	logic                       up_q;
	logic                       wv_s1;
	logic [AW-1:0]              wa_s1;
	logic [leb_pkg::CHAR_W-1:0] rd_data_q;
	logic                       out_valid_q;

	logic [PW-1:0]           nxt_cur, nxt_len;
	logic                    nxt_pend;
	logic [leb_pkg::EV_W-1:0] dec_ev;
	logic                    is_print, ins_ok, del_ok, enter;
	logic                    out_free;
	logic [PW-1:0]           src_inc, src_dec;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;

	assign src_inc = src_q + PW'(1);
	assign src_dec = src_q - PW'(1);

	// Key decode and next edit state
	always_comb begin
		is_print = (key_q >= leb_pkg::KEY_PRINT_LO) && (key_q <= leb_pkg::KEY_PRINT_HI);
		nxt_cur  = cur_q;
		nxt_len  = len_q;
		nxt_pend = 1'b0;
		dec_ev   = leb_pkg::EV_IGNORED;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		enter    = 1'b0;
		if (pend_q) begin
			unique case (key_q)
				leb_pkg::KEY_LEFT: begin
					if (cur_q != '0) nxt_cur = cur_q - PW'(1);
					dec_ev = leb_pkg::EV_MOVED;
				end
				leb_pkg::KEY_RIGHT: begin
					if (cur_q < len_q) nxt_cur = cur_q + PW'(1);
					dec_ev = leb_pkg::EV_MOVED;
				end
				leb_pkg::KEY_HOME: begin
					nxt_cur = '0;
					dec_ev  = leb_pkg::EV_MOVED;
				end
				leb_pkg::KEY_END: begin
					nxt_cur = len_q;
					dec_ev  = leb_pkg::EV_MOVED;
				end
				default: begin
					dec_ev = leb_pkg::EV_IGNORED;
				end
			endcase
		end else if (is_print) begin
			if ((leb_pkg::POS_W'(len_q) < maxlen_q) && (len_q < PW'(CAPACITY))
					&& (cur_q <= len_q)) begin
				ins_ok  = 1'b1;
				nxt_cur = cur_q + PW'(1);
				nxt_len = len_q + PW'(1);
				dec_ev  = leb_pkg::EV_INSERTED;
			end
		end else if (key_q == leb_pkg::KEY_PREFIX) begin
			nxt_pend = 1'b1;
			dec_ev   = leb_pkg::EV_PREFIX;
		end else if (key_q == leb_pkg::KEY_BKSP) begin
			if ((cur_q != '0) && (cur_q <= len_q)) begin
				del_ok  = 1'b1;
				nxt_cur = cur_q - PW'(1);
				nxt_len = len_q - PW'(1);
				dec_ev  = leb_pkg::EV_DELETED;
			end
		end else if (key_q == leb_pkg::KEY_ENTER) begin
			enter = 1'b1;
		end else if (key_q == leb_pkg::KEY_ESC) begin
			nxt_cur = '0;
			nxt_len = '0;
			dec_ev  = leb_pkg::EV_CANCELLED;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign sts.ins_ok   = ins_ok;
	assign sts.del_ok   = del_ok;
	assign sts.enter    = enter;
	assign sts.cnt_nz   = (cnt_q != '0);
	assign sts.out_free = out_free;

	// Store read port: shift source, first line entry, or next line entry
	assign rd_en = cmd.shift_step || cmd.start_emit || cmd.emit_char;
	always_comb begin
		if (cmd.shift_step) begin
			rd_addr = src_q[AW-1:0];
		end else if (cmd.emit_char) begin
			rd_addr = src_inc[AW-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	// Store: shifted character written in the cycle after its read; key written on commit
	always_ff @(posedge clk) begin
		if (wv_s1) begin
			mem[wa_s1] <= rd_data_q;
		end else if (cmd.commit && ins_ok) begin
			mem[cur_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			cur_q       <= '0;
			len_q       <= '0;
			maxlen_q    <= leb_pkg::MAX_LENGTH_RST;
			cnt_q       <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) maxlen_q <= cfg_wr_data;
			if (cmd.commit) begin
				cur_q  <= nxt_cur;
				len_q  <= nxt_len;
				pend_q <= nxt_pend;
			end else if (cmd.start_emit) begin
				cur_q <= '0;
				len_q <= '0;
			end
			if (cmd.start_ins || cmd.start_del) begin
				cnt_q <= len_q - cur_q;
			end else if (cmd.start_emit) begin
				cnt_q <= len_q;
			end else if (cmd.shift_step || cmd.emit_char) begin
				cnt_q <= cnt_q - PW'(1);
			end
			wv_s1 <= cmd.shift_step;
			if (cmd.commit || cmd.emit_char || cmd.emit_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_key) key_q <= key_code;
		if (cmd.start_ins || cmd.start_del) up_q <= cmd.start_ins;
		if (cmd.start_ins) begin
			src_q <= len_q - PW'(1);
		end else if (cmd.start_del) begin
			src_q <= cur_q;
		end else if (cmd.start_emit) begin
			src_q <= '0;
		end else if (cmd.shift_step) begin
			src_q <= up_q ? src_dec : src_inc;
		end else if (cmd.emit_char) begin
			src_q <= src_inc;
		end
		if (cmd.shift_step) begin
			wa_s1 <= up_q ? src_inc[AW-1:0] : src_dec[AW-1:0];
		end
		// Result register
		if (cmd.commit) begin
			kind       <= leb_pkg::KIND_STATUS;
			char_value <= '0;
			event_res  <= dec_ev;
			cursor     <= leb_pkg::POS_W'(nxt_cur);
			length     <= leb_pkg::POS_W'(nxt_len);
			last       <= 1'b1;
		end else if (cmd.emit_char) begin
			kind       <= leb_pkg::KIND_CHAR;
			char_value <= rd_data_q;
			event_res  <= leb_pkg::EV_SUBMITTED;
			cursor     <= '0;
			length     <= '0;
			last       <= 1'b0;
		end else if (cmd.emit_end) begin
			kind       <= leb_pkg::KIND_END;
			char_value <= '0;
			event_res  <= leb_pkg::EV_SUBMITTED;
			cursor     <= '0;
			length     <= '0;
			last       <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/line_edit_buffer.sv
// Line edit buffer: keyboard bytes in, status and submitted-line beats out.
//
// Input channel: one key_code byte per beat (in_valid/in_stall). Output
// channel: one result per beat (out_valid/out_stall) with kind, char_value,
// event_res, cursor, length and last; last marks the final beat of a key.
// max_length is written on cfg_wr_en/cfg_wr_data by the user only while idle,
// unchecked by the block. One key is handled at a time; in_stall is high from
// acceptance until the key's last result is loaded into the output register.
// Steps per key:
//   plain key, move, Esc, rejected edit: decode, then the status result
//   insert or backspace: length - cursor characters moved, one per cycle
//     through the single write port of the line store, then the status result
//   Enter: one line character per beat from the store read port, end beat last
// A stalled output holds its beat; the block waits and loses nothing.
// Reset clears cursor, length and the prefix flag and sets max_length to 32;
// the line store needs no clearing, as only entries below length are used.
module line_edit_buffer #(
	parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [leb_pkg::POS_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [leb_pkg::KEY_W-1:0]     key_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [leb_pkg::KIND_W-1:0]    kind,
	output logic [leb_pkg::CHAR_W-1:0]    char_value,
	output logic [leb_pkg::EV_W-1:0]      event_res,
	output logic [leb_pkg::POS_W-1:0]     cursor,
	output logic [leb_pkg::POS_W-1:0]     length,
	output logic                          last
);

	leb_pkg::cmd_t cmd;
	leb_pkg::sts_t sts;

	leb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	leb_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.key_code    (key_code),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.char_value  (char_value),
		.event_res   (event_res),
		.cursor      (cursor),
		.length      (length),
		.last        (last)
	);

	// An accepted key blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// Cursor never past the end of the line
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor <= length))
		else $error("cursor beyond line length");

	// Line characters are never the final beat of a key
	a_char_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == leb_pkg::KIND_CHAR)) |-> !last)
		else $error("line character flagged last");

	// Submitted-line beats report an emptied line
	a_submit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != leb_pkg::KIND_STATUS)) |->
			((event_res == leb_pkg::EV_SUBMITTED) && (cursor == '0) && (length == '0)))
		else $error("submitted beat with stale line state");

endmodule

// File: sim/tb_line_edit_buffer.sv
// Self-checking testbench for the line edit buffer: key beats in, checked result beats out.
module tb_line_edit_buffer;
	import leb_pkg::*;

	// One expected or observed result beat
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
		logic [EV_W-1:0]   ev;
		logic [POS_W-1:0]  cur;
		logic [POS_W-1:0]  len;
		logic              last;
	} beat_t;

	// Edit-line predictor plus the queue of beats it expects
	class line_scoreboard;
		logic [CHAR_W-1:0] line_chars [CAPACITY_DEF];
		int cur_pos = 0;
		int line_len = 0;
		int max_len = MAX_LENGTH_RST;
		bit prefix_armed = 1'b0;
		beat_t expected_beats [$];
		int fail_count = 0;
		int keys_seen = 0;
		int beats_checked = 0;

		function void push_beat(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c,
				logic [EV_W-1:0] e, logic l);
			beat_t b;
			b.kind = k;
			b.ch   = c;
			b.ev   = e;
			b.cur  = POS_W'(cur_pos);
			b.len  = POS_W'(line_len);
			b.last = l;
			expected_beats.push_back(b);
		endfunction

		// Update the line for one accepted key and queue its result beats
		function void apply_key(logic [KEY_W-1:0] key);
			int lim;
			int n;
			int i;
			logic [EV_W-1:0] ev;
			keys_seen++;
			lim = (max_len < CAPACITY_DEF) ? max_len : CAPACITY_DEF;
			ev = EV_IGNORED;
			if (prefix_armed) begin
				// second byte of an extended key; unknown codes are swallowed
				prefix_armed = 1'b0;
				case (key)
					KEY_LEFT: begin
						if (cur_pos > 0)
							cur_pos--;
						ev = EV_MOVED;
					end
					KEY_RIGHT: begin
						if (cur_pos < line_len)
							cur_pos++;
						ev = EV_MOVED;
					end
					KEY_HOME: begin
						cur_pos = 0;
						ev = EV_MOVED;
					end
					KEY_END: begin
						cur_pos = line_len;
						ev = EV_MOVED;
					end
					default: ;
				endcase
			end else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
				if (line_len < lim) begin
					for (i = line_len; i > cur_pos; i--)
						line_chars[i] = line_chars[i-1];
					line_chars[cur_pos] = key;
					line_len++;
					cur_pos++;
					ev = EV_INSERTED;
				end
			end else if (key == KEY_PREFIX) begin
				prefix_armed = 1'b1;
				ev = EV_PREFIX;
			end else if (key == KEY_BKSP) begin
				if (cur_pos > 0) begin
					for (i = cur_pos - 1; i + 1 < line_len; i++)
						line_chars[i] = line_chars[i+1];
					line_len--;
					cur_pos--;
					ev = EV_DELETED;
				end
			end else if (key == KEY_ENTER) begin
				// line goes out one char per beat, all beats show an empty line
				n = line_len;
				line_len = 0;
				cur_pos = 0;
				for (i = 0; i < n; i++)
					push_beat(KIND_CHAR, line_chars[i], EV_SUBMITTED, 1'b0);
				push_beat(KIND_END, '0, EV_SUBMITTED, 1'b1);
				return;
			end else if (key == KEY_ESC) begin
				line_len = 0;
				cur_pos = 0;
				ev = EV_CANCELLED;
			end
			push_beat(KIND_STATUS, '0, ev, 1'b1);
		endfunction

		function string beat_str(beat_t b);
			return $sformatf("kind=%0d char=%0d ev=%0d cur=%0d len=%0d last=%0d",
				b.kind, b.ch, b.ev, b.cur, b.len, b.last);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		// Compare one accepted result beat with the oldest expectation
		task check_beat(beat_t got);
			beat_t want;
			string diffs;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("beat %0d unexpected: %s", beats_checked,
					beat_str(got)));
				return;
			end
			want = expected_beats.pop_front();
			diffs = "";
			if (got.kind !== want.kind) diffs = {diffs, " kind"};
			if (got.ch !== want.ch)     diffs = {diffs, " char_value"};
			if (got.ev !== want.ev)     diffs = {diffs, " event_res"};
			if (got.cur !== want.cur)   diffs = {diffs, " cursor"};
			if (got.len !== want.len)   diffs = {diffs, " length"};
			if (got.last !== want.last) diffs = {diffs, " last"};
			if (diffs != "")
				report_mismatch($sformatf("beat %0d%s: got %s, exp %s", beats_checked,
					diffs, beat_str(got), beat_str(want)));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [POS_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [KEY_W-1:0]    key_code = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [CHAR_W-1:0]   char_value;
	logic [EV_W-1:0]     event_res;
	logic [POS_W-1:0]    cursor;
	logic [POS_W-1:0]    length;
	logic                last;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	line_scoreboard sb;

	line_edit_buffer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_code    (key_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.char_value  (char_value),
		.event_res   (event_res),
		.cursor      (cursor),
		.length      (length),
		.last        (last)
	);

	always #1 clk = ~clk;

	// Offer one key beat after a random gap, return once it is accepted
	task automatic send_key(input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_code <= key;
		do @(posedge clk); while (in_stall);
		sb.apply_key(key);
	endtask

	// Stop offering keys until every expected beat has come back
	task automatic wait_line_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_beats.size() != 0);
	endtask

	task automatic write_max_length(input logic [POS_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.max_len = value;
	endtask

	task automatic send_printable();
		send_key(KEY_W'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
	endtask

	// Mostly well-formed editing with some noise and broken prefix pairs
	task automatic send_random_edit();
		int pick;
		logic [KEY_W-1:0] nav;
		pick = $urandom_range(99);
		if (pick < 55) begin
			send_printable();
		end else if (pick < 67) begin
			case ($urandom_range(3))
				0: nav = KEY_LEFT;
				1: nav = KEY_RIGHT;
				2: nav = KEY_HOME;
				default: nav = KEY_END;
			endcase
			send_key(KEY_PREFIX);
			send_key(nav);
		end else if (pick < 76) begin
			send_key(KEY_BKSP);
		end else if (pick < 81) begin
			send_key(KEY_ENTER);
		end else if (pick < 83) begin
			send_key(KEY_ESC);
		end else if (pick < 88) begin
			send_key(KEY_PREFIX);
			send_key(KEY_W'($urandom_range(255)));
		end else begin
			send_key(KEY_W'($urandom_range(255)));
		end
	endtask

	// Result side: check accepted beats, stall at random or on a hold-off request
	initial begin : result_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_beat({kind, char_value, event_res, cursor, length, last});
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		logic [KEY_W-1:0] opening [25];
		int send_pcts [3];
		int recv_pcts [3];
		int phase;
		int seg;
		int g;
		int i;
		opening = '{KEY_PRINT_LO, KEY_PRINT_HI, KEY_PREFIX, KEY_LEFT, 8'd65,
			KEY_PREFIX, KEY_HOME, KEY_BKSP, KEY_PREFIX, KEY_LEFT,
			KEY_PREFIX, KEY_RIGHT, KEY_BKSP, KEY_PREFIX, KEY_END,
			KEY_PREFIX, KEY_PREFIX, KEY_PREFIX, KEY_ENTER, 8'd0,
			8'd255, KEY_ENTER, 8'd66, KEY_ESC, KEY_ENTER};
		send_pcts = '{32, 69, 0};
		recv_pcts = '{69, 32, 0};
		sb = new;
		send_idle_pct = send_pcts[0];
		recv_idle_pct = recv_pcts[0];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: inserts at the end and mid-line, moves at bounds, prefix misuse,
		// backspace at start, Enter on a non-empty and an empty line, Esc
		foreach (opening[i])
			send_key(opening[i]);

		// limit lowered below the held length
		wait_line_idle();
		write_max_length(6'd32);
		repeat (6) send_printable();
		wait_line_idle();
		write_max_length(6'd3);
		send_printable();
		repeat (3) send_key(KEY_BKSP);
		send_printable();
		send_key(KEY_BKSP);
		send_printable();

		// random editing under three idle mixes, new max_length per segment
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = send_pcts[phase];
			recv_idle_pct = recv_pcts[phase];
			for (seg = 0; seg < 4; seg++) begin
				g = phase * 4 + seg;
				wait_line_idle();
				if (g == 0)
					write_max_length(6'd0);
				else if (g == 1)
					write_max_length(6'd1);
				else if (g == 2)
					write_max_length(6'd63);
				else if ($urandom_range(3) == 0)
					write_max_length(POS_W'($urandom_range(63)));
				else
					write_max_length(POS_W'($urandom_range(8, 32)));
				for (i = 0; i < 5; i++)
					send_random_edit();
			end
		end

		// long output hold-off while keys keep coming: fill to capacity with inserts at
		// the cursor, then at the front, overflow, then submit the full line
		wait_line_idle();
		write_max_length(6'd63);
		hold_requests++;
		repeat (20) send_printable();
		send_key(KEY_PREFIX);
		send_key(KEY_HOME);
		repeat (16) send_printable();
		send_key(KEY_ENTER);

		wait_line_idle();
		repeat (20) @(posedge clk);
		$display("Summary: %0d keys applied and %0d result beats checked under three idle mixes,",
			sb.keys_seen, sb.beats_checked);
		$display("max_length from 0 to 63, a lowered limit, and a full line behind a long hold-off.");
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#2000000;
		$display("Timeout with %0d beats still expected", sb.expected_beats.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: line_edit_buffer.f
rtl/leb_pkg.sv
rtl/leb_ctrl.sv
rtl/leb_dpath.sv
rtl/line_edit_buffer.sv
sim/tb_line_edit_buffer.sv
